@@ sv/tfdc_pkg.sv @@
// Shared types and constants for the thermal fan duty controller.
// Holds field widths, register index codes, the register bank type and its reset image.
// No dependencies.
`default_nettype none

package tfdc_pkg;

   localparam int TEMP_W     = 10;
   localparam int HYST_W     = 8;
   localparam int DUTY_W     = 15;
   localparam int TICK_W     = 6;
   localparam int SETTLE_W   = 4;

   // multiplier: signed duty difference times unsigned temperature or tick offset
   localparam int MUL_A_W    = DUTY_W + 1;
   localparam int MUL_B_W    = TEMP_W + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W + 1;

   // product magnitude stays below 1022 * 32767, so 25 bits cover it
   localparam int DIVD_W     = 25;
   localparam int DIVS_W     = TEMP_W;
   localparam int SUM_W      = DIVD_W + 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_START_TEMP  = 3'd0,
      REG_STOP_HYST   = 3'd1,
      REG_FULL_TEMP   = 3'd2,
      REG_START_DUTY  = 3'd3,
      REG_RAMP_STEP   = 3'd4,
      REG_RUN_THRESH  = 3'd5,
      REG_CHECK_MIN   = 3'd6,
      REG_CHECK_MAX   = 3'd7
   } tfdc_reg_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] start_temp;
      logic [HYST_W-1:0]        stop_hysteresis;
      logic signed [TEMP_W-1:0] full_temp;
      logic [DUTY_W-1:0]        start_duty;
      logic [DUTY_W-1:0]        ramp_step;
      logic [DUTY_W-1:0]        run_threshold;
      logic [DUTY_W-1:0]        check_min_duty;
      logic [DUTY_W-1:0]        check_max_duty;
   } tfdc_cfg_type;

   localparam tfdc_cfg_type CFG_RESET = '{
      start_temp:      10'sd60,
      stop_hysteresis: 8'd3,
      full_temp:       10'sd100,
      start_duty:      15'd7000,
      ramp_step:       15'd320,
      run_threshold:   15'd200,
      check_min_duty:  15'd5000,
      check_max_duty:  15'd11000
   };

endpackage

`default_nettype wire

@@ sv/tfdc_div.sv @@
// Shared restoring divider: one quotient bit per cycle, unsigned magnitudes.
// Depends on tfdc_pkg for the dividend and divisor widths.
`default_nettype none

module tfdc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tfdc_pkg::DIVD_W-1:0] dividend,
   input  logic [tfdc_pkg::DIVS_W-1:0] divisor,
   output logic                        done,
   output logic [tfdc_pkg::DIVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(tfdc_pkg::DIVD_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(tfdc_pkg::DIVD_W - 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [tfdc_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [tfdc_pkg::DIVD_W-1:0] quot_ff, quot_in;
   logic [tfdc_pkg::DIVS_W-1:0] dsr_ff, dsr_in;
   logic [tfdc_pkg::DIVS_W:0]   shifted;
   logic [tfdc_pkg::DIVS_W+1:0] trial;
   logic                        take;

   always_comb begin
      shifted = {rem_ff, quot_ff[tfdc_pkg::DIVD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      take    = ~trial[tfdc_pkg::DIVS_W+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dsr_in  = dsr_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, keep the difference when it fits
         rem_in  = take ? trial[tfdc_pkg::DIVS_W-1:0] : shifted[tfdc_pkg::DIVS_W-1:0];
         quot_in = {quot_ff[tfdc_pkg::DIVD_W-2:0], take};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

@@ sv/tfdc_csr.sv @@
// Control register bank behind an APB-style port, eight registers at 4-byte spacing.
// Depends on tfdc_pkg for the register type, index codes and reset image.
`default_nettype none

module tfdc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tfdc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tfdc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tfdc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output tfdc_pkg::tfdc_cfg_type          cfg
);

   localparam int PAD_T = tfdc_pkg::CSR_DATA_W - tfdc_pkg::TEMP_W;

   tfdc_pkg::tfdc_cfg_type cfg_ff, cfg_in;
   tfdc_pkg::tfdc_reg_type reg_idx;
   logic                   wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = tfdc_pkg::tfdc_reg_type'(csr_paddr[tfdc_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            tfdc_pkg::REG_START_TEMP:
               cfg_in.start_temp = $signed(csr_pwdata[tfdc_pkg::TEMP_W-1:0]);
            tfdc_pkg::REG_STOP_HYST:
               cfg_in.stop_hysteresis = csr_pwdata[tfdc_pkg::HYST_W-1:0];
            tfdc_pkg::REG_FULL_TEMP:
               cfg_in.full_temp = $signed(csr_pwdata[tfdc_pkg::TEMP_W-1:0]);
            tfdc_pkg::REG_START_DUTY:
               cfg_in.start_duty = csr_pwdata[tfdc_pkg::DUTY_W-1:0];
            tfdc_pkg::REG_RAMP_STEP:
               cfg_in.ramp_step = csr_pwdata[tfdc_pkg::DUTY_W-1:0];
            tfdc_pkg::REG_RUN_THRESH:
               cfg_in.run_threshold = csr_pwdata[tfdc_pkg::DUTY_W-1:0];
            tfdc_pkg::REG_CHECK_MIN:
               cfg_in.check_min_duty = csr_pwdata[tfdc_pkg::DUTY_W-1:0];
            tfdc_pkg::REG_CHECK_MAX:
               cfg_in.check_max_duty = csr_pwdata[tfdc_pkg::DUTY_W-1:0];
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         tfdc_pkg::REG_START_TEMP:
            csr_prdata = {{PAD_T{cfg_ff.start_temp[tfdc_pkg::TEMP_W-1]}}, cfg_ff.start_temp};
         tfdc_pkg::REG_STOP_HYST:
            csr_prdata = tfdc_pkg::CSR_DATA_W'(cfg_ff.stop_hysteresis);
         tfdc_pkg::REG_FULL_TEMP:
            csr_prdata = {{PAD_T{cfg_ff.full_temp[tfdc_pkg::TEMP_W-1]}}, cfg_ff.full_temp};
         tfdc_pkg::REG_START_DUTY:
            csr_prdata = tfdc_pkg::CSR_DATA_W'(cfg_ff.start_duty);
         tfdc_pkg::REG_RAMP_STEP:
            csr_prdata = tfdc_pkg::CSR_DATA_W'(cfg_ff.ramp_step);
         tfdc_pkg::REG_RUN_THRESH:
            csr_prdata = tfdc_pkg::CSR_DATA_W'(cfg_ff.run_threshold);
         tfdc_pkg::REG_CHECK_MIN:
            csr_prdata = tfdc_pkg::CSR_DATA_W'(cfg_ff.check_min_duty);
         tfdc_pkg::REG_CHECK_MAX:
            csr_prdata = tfdc_pkg::CSR_DATA_W'(cfg_ff.check_max_duty);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= tfdc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ sv/thermal_fan_duty_controller_unit.sv @@
// channel  dir  handshake                 payload
// req      in   req_valid / req_stall     inside, outside and aux temperature
// rsp      out  rsp_valid / rsp_stall     duty value, duty written, fan running
// csr      in   APB-style, pready tied 1  eight control registers, 4-byte spacing
//
// A beat's result is registered after acceptance through these steps: max of the
// temperatures, one multiply, a 25-step pass through the shared restoring
// divider, target selection, then slew and commit. The next beat is taken only
// once the sequencer is back in idle, so beats never overlap in the datapath.
// req_stall is high from acceptance until the result is committed; a new beat
// is taken while an earlier result still waits under rsp_stall.
// Under rsp_stall the sequencer holds in its commit step. Synchronous reset
// clears loop state and restores the register defaults.
//
// Top level of the thermal fan duty controller: sequencer, datapath, result register.
// Depends on tfdc_pkg, tfdc_csr and tfdc_div.
`default_nettype none

module thermal_fan_duty_controller_unit #(
   parameter int CHECK_TICKS     = 50,
   parameter int SETTLE_TICKS    = 10,
   parameter int DUTY_FULL_SCALE = 20000
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [tfdc_pkg::TEMP_W-1:0] req_inside_temp,
   input  logic signed [tfdc_pkg::TEMP_W-1:0] req_outside_temp,
   input  logic signed [tfdc_pkg::TEMP_W-1:0] req_aux_temp,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tfdc_pkg::DUTY_W-1:0]       rsp_duty_value,
   output logic                              rsp_duty_written,
   output logic                              rsp_fan_running,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tfdc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tfdc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tfdc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int SWEEP_HALF = CHECK_TICKS / 2;
   localparam int SWEEP_DIV  = (SWEEP_HALF > 1) ? SWEEP_HALF - 1 : 1;

   localparam logic [tfdc_pkg::TICK_W-1:0]   TICKS_C  = tfdc_pkg::TICK_W'(CHECK_TICKS);
   localparam logic [tfdc_pkg::TICK_W-1:0]   HALF_C   = tfdc_pkg::TICK_W'(SWEEP_HALF);
   localparam logic [tfdc_pkg::DIVS_W-1:0]   SDIV_C   = tfdc_pkg::DIVS_W'(SWEEP_DIV);
   localparam logic [tfdc_pkg::SETTLE_W-1:0] SETTLE_C = tfdc_pkg::SETTLE_W'(SETTLE_TICKS);
   localparam logic [tfdc_pkg::DUTY_W-1:0]   FULL_C   = tfdc_pkg::DUTY_W'(DUTY_FULL_SCALE);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MAX  = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_TGT  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   function automatic logic [tfdc_pkg::DUTY_W-1:0] sat_duty(
      input logic signed [tfdc_pkg::SUM_W-1:0] v
   );
      logic [tfdc_pkg::DUTY_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed(tfdc_pkg::SUM_W'(FULL_C))) begin
         r = FULL_C;
      end else begin
         r = v[tfdc_pkg::DUTY_W-1:0];
      end
      return r;
   endfunction

   tfdc_pkg::tfdc_cfg_type cfg;

   state_type state_ff, state_in;

   // beat payload and intermediate results
   logic signed [tfdc_pkg::TEMP_W-1:0] temp0_ff, temp1_ff, temp2_ff;
   logic signed [tfdc_pkg::TEMP_W-1:0] tmax_ff, tmax_in;
   logic                               fan_next_ff, fan_next_in;
   logic signed [tfdc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [tfdc_pkg::DIVS_W-1:0]        divisor_ff, divisor_in;
   logic                               div_go_ff, div_go_in;
   logic [tfdc_pkg::DUTY_W-1:0]        target_ff, target_in;

   // loop state
   logic [tfdc_pkg::DUTY_W-1:0]   current_duty_ff, current_duty_in;
   logic                          fan_on_ff, fan_on_in;
   logic [tfdc_pkg::SETTLE_W-1:0] settle_ff, settle_in;
   logic                          ramp_en_ff, ramp_en_in;
   logic                          running_ff, running_in;
   logic [tfdc_pkg::TICK_W-1:0]   check_tick_ff, check_tick_in;
   logic                          check_done_ff, check_done_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tfdc_pkg::DUTY_W-1:0] rsp_duty_ff, rsp_duty_in;
   logic                        rsp_written_ff, rsp_written_in;
   logic                        rsp_running_ff, rsp_running_in;

   logic                               accept;
   logic                               commit;
   logic                               sweep_mode;
   logic                               sweep_low;
   logic signed [tfdc_pkg::TEMP_W-1:0] t01;
   logic signed [tfdc_pkg::TEMP_W:0]   tmax_x, start_x, full_x, off_temp, t_rel, span_t;
   logic [tfdc_pkg::TICK_W-1:0]        tick_off;
   logic signed [tfdc_pkg::MUL_A_W-1:0] mul_a;
   logic [tfdc_pkg::MUL_B_W-1:0]       mul_b;
   logic [tfdc_pkg::PROD_W-1:0]        prod_abs;
   logic                               prod_neg;
   logic                               div_done;
   logic [tfdc_pkg::DIVD_W-1:0]        div_quot;
   logic [tfdc_pkg::DUTY_W-1:0]        lin_base;
   logic                               lin_sub;
   logic signed [tfdc_pkg::SUM_W-1:0]  base_x, quot_x, lin_sum;
   logic [tfdc_pkg::DUTY_W-1:0]        lin_duty;
   logic [tfdc_pkg::DUTY_W-1:0]        cd0;
   logic [tfdc_pkg::SETTLE_W-1:0]      sc0, sc1;
   logic                               re0, rf0;
   logic [tfdc_pkg::DUTY_W-1:0]        gap, slewed;

   tfdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tfdc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (prod_abs[tfdc_pkg::DIVD_W-1:0]),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign commit    = (state_ff == ST_DONE) & (~rsp_valid_ff | ~rsp_stall);

   assign sweep_mode = (check_tick_ff < TICKS_C);
   assign sweep_low  = (check_tick_ff < HALF_C);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      div_go_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MAX;
         end
         ST_MAX: state_in = ST_MUL;
         ST_MUL: begin
            state_in  = ST_DIV;
            div_go_in = 1'b1;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_TGT;
         end
         ST_TGT: state_in = ST_DONE;
         ST_DONE: begin
            if (commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hottest sample, switch decision and the multiply feeding the divider
   always_comb begin
      t01     = (temp1_ff > temp0_ff) ? temp1_ff : temp0_ff;
      tmax_in = (state_ff == ST_MAX) ? ((temp2_ff > t01) ? temp2_ff : t01) : tmax_ff;

      tmax_x   = {tmax_ff[tfdc_pkg::TEMP_W-1], tmax_ff};
      start_x  = {cfg.start_temp[tfdc_pkg::TEMP_W-1], cfg.start_temp};
      full_x   = {cfg.full_temp[tfdc_pkg::TEMP_W-1], cfg.full_temp};
      off_temp = start_x - $signed({{(tfdc_pkg::TEMP_W + 1 - tfdc_pkg::HYST_W){1'b0}},
                                    cfg.stop_hysteresis});
      t_rel    = tmax_x - start_x;
      span_t   = full_x - start_x;

      // switch-on wins over switch-off when the hysteresis is zero
      fan_next_in = fan_on_ff;
      if (tmax_x <= off_temp) fan_next_in = 1'b0;
      if (tmax_x >= start_x) fan_next_in = 1'b1;
      if (state_ff != ST_MUL) fan_next_in = fan_next_ff;

      tick_off = sweep_low ? check_tick_ff : check_tick_ff - HALF_C;
      if (sweep_mode) begin
         mul_a      = $signed({1'b0, cfg.check_max_duty}) - $signed({1'b0, cfg.check_min_duty});
         mul_b      = tfdc_pkg::MUL_B_W'(tick_off);
         divisor_in = SDIV_C;
      end else begin
         mul_a      = $signed({1'b0, FULL_C}) - $signed({1'b0, cfg.start_duty});
         mul_b      = t_rel;
         divisor_in = span_t[tfdc_pkg::DIVS_W-1:0];
      end
      prod_in = tfdc_pkg::PROD_W'(mul_a) * tfdc_pkg::PROD_W'($signed({1'b0, mul_b}));
      if (state_ff != ST_MUL) begin
         prod_in    = prod_ff;
         divisor_in = divisor_ff;
      end

      prod_neg = prod_ff[tfdc_pkg::PROD_W-1];
      prod_abs = prod_neg ? tfdc_pkg::PROD_W'(-prod_ff) : prod_ff;
   end

   // target duty from the truncated quotient; the sign folds into add or subtract
   always_comb begin
      if (sweep_mode) begin
         lin_base = sweep_low ? cfg.check_min_duty : cfg.check_max_duty;
         lin_sub  = sweep_low ? prod_neg : ~prod_neg;
      end else begin
         lin_base = cfg.start_duty;
         lin_sub  = prod_neg;
      end
      base_x   = $signed(tfdc_pkg::SUM_W'(lin_base));
      quot_x   = $signed(tfdc_pkg::SUM_W'(div_quot));
      lin_sum  = lin_sub ? base_x - quot_x : base_x + quot_x;
      lin_duty = sat_duty(lin_sum);

      if (sweep_mode) begin
         target_in = lin_duty;
      end else if (!fan_next_ff) begin
         target_in = '0;
      end else if (tmax_x >= full_x) begin
         target_in = FULL_C;
      end else if (tmax_x < start_x) begin
         target_in = sat_duty($signed(tfdc_pkg::SUM_W'(cfg.start_duty)));
      end else begin
         target_in = lin_duty;
      end
      if (state_ff != ST_TGT) target_in = target_ff;
   end

   // loop state update and result beat
   always_comb begin
      cd0 = check_done_ff ? '0 : current_duty_ff;
      sc0 = check_done_ff ? '0 : settle_ff;
      re0 = check_done_ff ? 1'b0 : ramp_en_ff;
      rf0 = check_done_ff ? 1'b0 : running_ff;
      sc1 = sc0 + 1'b1;

      if (cd0 < target_ff) begin
         gap    = target_ff - cd0;
         slewed = (gap > cfg.ramp_step) ? cd0 + cfg.ramp_step : target_ff;
      end else begin
         gap    = cd0 - target_ff;
         slewed = (gap > cfg.ramp_step) ? cd0 - cfg.ramp_step : target_ff;
      end

      current_duty_in = current_duty_ff;
      fan_on_in       = fan_on_ff;
      settle_in       = settle_ff;
      ramp_en_in      = ramp_en_ff;
      running_in      = running_ff;
      check_tick_in   = check_tick_ff;
      check_done_in   = check_done_ff;
      rsp_duty_in     = rsp_duty_ff;
      rsp_written_in  = rsp_written_ff;
      rsp_running_in  = rsp_running_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;

      if (commit) begin
         rsp_valid_in = 1'b1;
         if (sweep_mode) begin
            current_duty_in = target_ff;
            check_tick_in   = check_tick_ff + 1'b1;
            check_done_in   = (check_tick_in >= TICKS_C);
            settle_in       = sc0;
            ramp_en_in      = re0;
            running_in      = 1'b1;
            rsp_written_in  = 1'b1;
         end else begin
            fan_on_in     = fan_next_ff;
            check_done_in = 1'b0;
            if (sc1 >= SETTLE_C) begin
               settle_in  = '0;
               ramp_en_in = 1'b1;
            end else begin
               settle_in  = sc1;
               ramp_en_in = re0;
            end
            if (ramp_en_in) begin
               current_duty_in = slewed;
               running_in      = (slewed > cfg.run_threshold);
               rsp_written_in  = 1'b1;
            end else begin
               current_duty_in = cd0;
               running_in      = rf0;
               rsp_written_in  = check_done_ff;
            end
         end
         rsp_duty_in    = current_duty_in;
         rsp_running_in = running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         div_go_ff       <= 1'b0;
         current_duty_ff <= '0;
         fan_on_ff       <= 1'b0;
         settle_ff       <= '0;
         ramp_en_ff      <= 1'b0;
         running_ff      <= 1'b0;
         check_tick_ff   <= '0;
         check_done_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         div_go_ff       <= div_go_in;
         current_duty_ff <= current_duty_in;
         fan_on_ff       <= fan_on_in;
         settle_ff       <= settle_in;
         ramp_en_ff      <= ramp_en_in;
         running_ff      <= running_in;
         check_tick_ff   <= check_tick_in;
         check_done_ff   <= check_done_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         temp0_ff <= req_inside_temp;
         temp1_ff <= req_outside_temp;
         temp2_ff <= req_aux_temp;
      end
      tmax_ff        <= tmax_in;
      fan_next_ff    <= fan_next_in;
      prod_ff        <= prod_in;
      divisor_ff     <= divisor_in;
      target_ff      <= target_in;
      rsp_duty_ff    <= rsp_duty_in;
      rsp_written_ff <= rsp_written_in;
      rsp_running_ff <= rsp_running_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty_value   = rsp_duty_ff;
   assign rsp_duty_written = rsp_written_ff;
   assign rsp_fan_running  = rsp_running_ff;

`ifndef SYNTHESIS
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside the commit step");

   a_duty_in_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_duty_ff <= FULL_C))
      else $error("duty beyond full scale");

   a_sweep_end_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && check_done_ff) |-> (rsp_running_ff && rsp_written_ff))
      else $error("last sweep beat lost its running or written flag");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide step");

   a_tick_bound: assert property (@(posedge clock) disable iff (reset)
      check_tick_ff <= TICKS_C)
      else $error("sweep tick ran past its end");
`endif

endmodule

`default_nettype wire
